>>> sv/ansi_csi_sequence_parser_core_macros.svh
// Assertion macros for the CSI parser core.
// IMP checks a same-cycle implication, NXT checks the cycle after.
`ifndef ANSI_CSI_SEQUENCE_PARSER_CORE_MACROS_SVH
`define ANSI_CSI_SEQUENCE_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ACSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("acsp: same-cycle check failed");
`define ACSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("acsp: next-cycle check failed");
`else
`define ACSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ACSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/acsp_pkg.sv
package acsp_pkg;

    localparam int NUM_W = 20;

    localparam logic [7:0] CH_ESC      = 8'd27;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_UA       = 8'h41;
    localparam logic [7:0] CH_UH       = 8'h48;
    localparam logic [7:0] CH_UJ       = 8'h4A;
    localparam logic [7:0] CH_UK       = 8'h4B;
    localparam logic [7:0] CH_LH       = 8'h68;
    localparam logic [7:0] CH_LL       = 8'h6C;
    localparam logic [7:0] CH_LM       = 8'h6D;

    localparam logic [NUM_W-1:0] NUM_LIMIT = 20'd999999;

    typedef enum logic [2:0] {
        PST_BRACKET,
        PST_QMARK,
        PST_NUM1,
        PST_SEMI,
        PST_NUM2F,
        PST_NUM2,
        PST_FINAL
    } t_pst;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_PARSE,
        FSM_REPLAY,
        FSM_CMD
    } t_fsm;

    typedef struct packed {
        t_pst             state;
        logic [NUM_W-1:0] n1;
        logic [NUM_W-1:0] n2;
        logic             done;
        logic             fail;
    } t_step;

endpackage

>>> sv/acsp_parse.sv
module acsp_parse (
    input  acsp_pkg::t_pst                  i_state,
    input  logic [7:0]                      i_byte,
    input  logic [acsp_pkg::NUM_W-1:0]      i_n1,
    input  logic [acsp_pkg::NUM_W-1:0]      i_n2,
    output acsp_pkg::t_step                 o_step
);
    import acsp_pkg::*;

    logic             is_dig;
    logic             is_fin;
    logic [3:0]       digit;
    logic [NUM_W-1:0] acc_in;
    logic [NUM_W+3:0] prod;
    logic [NUM_W-1:0] acc_out;

    // shared decimal accumulator: acc*10 + digit, saturating
    always_comb begin
        is_dig = (i_byte >= CH_0) && (i_byte <= CH_9);
        is_fin = ((i_byte >= CH_UA) && (i_byte <= CH_UH)) || (i_byte == CH_UJ) ||
                 (i_byte == CH_UK) || (i_byte == CH_LH) || (i_byte == CH_LL) ||
                 (i_byte == CH_LM);
        digit  = i_byte[3:0];
        case (i_state)
            PST_NUM1: acc_in = i_n1;
            PST_NUM2: acc_in = i_n2;
            default:  acc_in = '0;
        endcase
        prod    = (NUM_W+4)'(acc_in) * (NUM_W+4)'(10) + (NUM_W+4)'(digit);
        acc_out = (prod > (NUM_W+4)'(NUM_LIMIT)) ? NUM_LIMIT : prod[NUM_W-1:0];
    end

    // a non-digit ends a number and falls through to the ';' / final check
    always_comb begin
        o_step.state = i_state;
        o_step.n1    = i_n1;
        o_step.n2    = i_n2;
        o_step.done  = 1'b0;
        o_step.fail  = 1'b0;
        case (i_state)
            PST_BRACKET: begin
                if (i_byte == CH_LBRACKET) begin
                    o_step.state = PST_QMARK;
                end else begin
                    o_step.fail = 1'b1;
                end
            end
            PST_QMARK, PST_NUM1, PST_SEMI: begin
                if (is_dig && i_state != PST_SEMI) begin
                    o_step.n1    = acc_out;
                    o_step.state = PST_NUM1;
                end else if (i_byte == CH_QMARK && i_state == PST_QMARK) begin
                    o_step.state = PST_QMARK;
                end else begin
                    if (i_state == PST_QMARK) begin
                        o_step.n1 = NUM_W'(1);
                    end
                    if (i_byte == CH_SEMI) begin
                        o_step.state = PST_NUM2F;
                    end else if (is_fin) begin
                        o_step.state = PST_FINAL;
                        o_step.done  = 1'b1;
                    end else begin
                        o_step.fail = 1'b1;
                    end
                end
            end
            PST_NUM2F: begin
                if (is_dig) begin
                    o_step.n2    = acc_out;
                    o_step.state = PST_NUM2;
                end else begin
                    o_step.fail = 1'b1;
                end
            end
            PST_NUM2: begin
                if (is_dig) begin
                    o_step.n2 = acc_out;
                end else if (is_fin) begin
                    o_step.state = PST_FINAL;
                    o_step.done  = 1'b1;
                end else begin
                    o_step.fail = 1'b1;
                end
            end
            default: begin
                if (is_fin) begin
                    o_step.done = 1'b1;
                end else begin
                    o_step.fail = 1'b1;
                end
            end
        endcase
    end

endmodule

>>> sv/ansi_csi_sequence_parser_core.sv
// Console byte filter for ANSI CSI sequences. Outside a sequence a byte goes
// straight to the output as a character, one transfer per cycle unless the
// output stalls. ESC opens a sequence: the bytes that follow are held in a
// SEQ_BUFFER_BYTES-deep buffer and each is fed, in the cycle after it is
// taken, through one shared step unit (parser state plus a saturating decimal
// accumulator); the input is held off while it is parsed. A valid final
// character yields one command transfer. An illegal byte, a full buffer or a
// new ESC inside a sequence replays the held bytes as characters, one buffer
// read per cycle unless the output stalls, and holds the input off until the
// replay ends. The input is only taken while the sequencer is idle and the
// output register is free or being emptied. No clearing pass after reset.
`include "ansi_csi_sequence_parser_core_macros.svh"

module ansi_csi_sequence_parser_core #(
    parameter int SEQ_BUFFER_BYTES = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_byte_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_kind,
    output logic [7:0]                      o_char_out,
    output logic [7:0]                      o_final_char,
    output logic [acsp_pkg::NUM_W-1:0]      o_first_number,
    output logic [acsp_pkg::NUM_W-1:0]      o_second_number,
    output logic                            o_last
);
    import acsp_pkg::*;

    localparam int IDX_W = $clog2(SEQ_BUFFER_BYTES);
    localparam int LEN_W = $clog2(SEQ_BUFFER_BYTES + 1);

    t_fsm             r_fsm, n_fsm;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_buf [SEQ_BUFFER_BYTES];
    logic [7:0]       r_byte, n_byte;
    t_pst             r_pst, n_pst;
    logic [NUM_W-1:0] r_n1, n_n1;
    logic [NUM_W-1:0] r_n2, n_n2;
    logic [IDX_W-1:0] r_rep_idx, n_rep_idx;
    logic [IDX_W-1:0] r_rep_end, n_rep_end;
    logic             r_rep_esc, n_rep_esc;

    logic             r_out_valid, n_out_valid;
    logic             r_kind, n_kind;
    logic [7:0]       r_char, n_char;
    logic [7:0]       r_final, n_final;
    logic [NUM_W-1:0] r_on1, n_on1;
    logic [NUM_W-1:0] r_on2, n_on2;
    logic             r_last, n_last;

    logic             w_en;
    logic [IDX_W-1:0] w_idx;
    logic [7:0]       w_data;

    logic             out_free;
    logic             in_acc;
    logic             full;
    logic             rep_at_end;
    t_step            step;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_fsm == FSM_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign full       = (r_len == LEN_W'(SEQ_BUFFER_BYTES));
    assign rep_at_end = (r_rep_idx == r_rep_end);

    acsp_parse u_parse (
        .i_state (r_pst),
        .i_byte  (r_byte),
        .i_n1    (r_n1),
        .i_n2    (r_n2),
        .o_step  (step)
    );

    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            FSM_IDLE: begin
                if (in_acc) begin
                    if (i_byte_in == CH_ESC) begin
                        n_fsm = (r_len != '0) ? FSM_REPLAY : FSM_IDLE;
                    end else if (r_len != '0) begin
                        n_fsm = FSM_PARSE;
                    end
                end
            end
            FSM_PARSE: begin
                if (full || step.fail) begin
                    n_fsm = FSM_REPLAY;
                end else if (step.done) begin
                    n_fsm = FSM_CMD;
                end else begin
                    n_fsm = FSM_IDLE;
                end
            end
            FSM_REPLAY: begin
                if (out_free && rep_at_end) begin
                    n_fsm = FSM_IDLE;
                end
            end
            FSM_CMD: begin
                if (out_free) begin
                    n_fsm = FSM_IDLE;
                end
            end
            default: n_fsm = FSM_IDLE;
        endcase
    end

    always_comb begin
        n_len       = r_len;
        n_byte      = r_byte;
        n_pst       = r_pst;
        n_n1        = r_n1;
        n_n2        = r_n2;
        n_rep_idx   = r_rep_idx;
        n_rep_end   = r_rep_end;
        n_rep_esc   = r_rep_esc;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_char      = r_char;
        n_final     = r_final;
        n_on1       = r_on1;
        n_on2       = r_on2;
        n_last      = r_last;
        w_en        = 1'b0;
        w_idx       = r_len[IDX_W-1:0];
        w_data      = i_byte_in;
        case (r_fsm)
            FSM_IDLE: begin
                if (in_acc) begin
                    if (i_byte_in == CH_ESC) begin
                        if (r_len == '0) begin
                            w_en   = 1'b1;
                            w_idx  = '0;
                            w_data = CH_ESC;
                            n_len  = LEN_W'(1);
                            n_pst  = PST_BRACKET;
                            n_n1   = '0;
                            n_n2   = '0;
                        end else begin
                            n_rep_idx = '0;
                            n_rep_end = IDX_W'(r_len - LEN_W'(1));
                            n_rep_esc = 1'b1;
                        end
                    end else if (r_len == '0) begin
                        n_out_valid = 1'b1;
                        n_kind      = 1'b0;
                        n_char      = i_byte_in;
                        n_final     = '0;
                        n_on1       = '0;
                        n_on2       = '0;
                        n_last      = 1'b1;
                    end else begin
                        w_en   = 1'b1;
                        n_len  = r_len + LEN_W'(1);
                        n_byte = i_byte_in;
                    end
                end
            end
            FSM_PARSE: begin
                if (full || step.fail) begin
                    n_rep_idx = '0;
                    n_rep_end = IDX_W'(r_len - LEN_W'(1));
                    n_rep_esc = 1'b0;
                end else begin
                    n_pst = step.state;
                    n_n1  = step.n1;
                    n_n2  = step.n2;
                end
            end
            FSM_REPLAY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b0;
                    n_char      = r_buf[r_rep_idx];
                    n_final     = '0;
                    n_on1       = '0;
                    n_on2       = '0;
                    n_last      = rep_at_end;
                    n_rep_idx   = r_rep_idx + IDX_W'(1);
                    if (rep_at_end) begin
                        // the escape that cut the sequence opens the next one
                        if (r_rep_esc) begin
                            w_en   = 1'b1;
                            w_idx  = '0;
                            w_data = CH_ESC;
                            n_len  = LEN_W'(1);
                            n_pst  = PST_BRACKET;
                            n_n1   = '0;
                            n_n2   = '0;
                        end else begin
                            n_len = '0;
                        end
                    end
                end
            end
            FSM_CMD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b1;
                    n_char      = '0;
                    n_final     = r_byte;
                    n_on1       = r_n1;
                    n_on2       = r_n2;
                    n_last      = 1'b1;
                    n_len       = '0;
                end
            end
            default: begin
                n_len = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= FSM_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_pst     <= n_pst;
        r_n1      <= n_n1;
        r_n2      <= n_n2;
        r_rep_idx <= n_rep_idx;
        r_rep_end <= n_rep_end;
        r_rep_esc <= n_rep_esc;
        r_kind    <= n_kind;
        r_char    <= n_char;
        r_final   <= n_final;
        r_on1     <= n_on1;
        r_on2     <= n_on2;
        r_last    <= n_last;
        if (w_en) begin
            r_buf[w_idx] <= w_data;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_char_out      = r_char;
    assign o_final_char    = r_final;
    assign o_first_number  = r_on1;
    assign o_second_number = r_on2;
    assign o_last          = r_last;

    `ACSP_ASSERT_IMP(a_len_room, i_clk, i_rst_n, r_fsm == FSM_IDLE, r_len < LEN_W'(SEQ_BUFFER_BYTES))
    `ACSP_ASSERT_IMP(a_cmd_last, i_clk, i_rst_n, r_out_valid && r_kind, r_last)
    `ACSP_ASSERT_IMP(a_rep_range, i_clk, i_rst_n, r_fsm == FSM_REPLAY, r_rep_idx <= r_rep_end)
    `ACSP_ASSERT_NXT(a_esc_replay, i_clk, i_rst_n, in_acc && (i_byte_in == CH_ESC) && (r_len != '0), r_fsm == FSM_REPLAY)

endmodule

>>> tb/sv/ansi_csi_sequence_parser_core_test.sv
`timescale 1ns / 1ps

module ansi_csi_sequence_parser_core_test;
    import acsp_pkg::*;

    localparam int unsigned SEQ_BYTES     = 10;
    localparam int unsigned RANDOM_BYTES  = 278;
    localparam int unsigned DIRECTED_ROWS = 32;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned TAIL_CYCLES   = 16;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    typedef enum logic [2:0] {
        ST_ESC,
        ST_BRACKET,
        ST_LEAD,
        ST_NUM1,
        ST_SEMI,
        ST_NUM2F,
        ST_NUM2,
        ST_FINAL
    } t_scan_state;

    typedef struct packed {
        logic             kind;
        logic [7:0]       ch;
        logic [7:0]       fin;
        logic [NUM_W-1:0] n1;
        logic [NUM_W-1:0] n2;
        logic             last;
    } t_csi_result;

    typedef struct packed {
        logic [7:0]  data;
        logic        typed;
        t_csi_result want;
    } t_stim_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [7:0]       i_byte_in = 8'h00;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_kind;
    logic [7:0]       o_char_out;
    logic [7:0]       o_final_char;
    logic [NUM_W-1:0] o_first_number;
    logic [NUM_W-1:0] o_second_number;
    logic             o_last;

    ansi_csi_sequence_parser_core #(
        .SEQ_BUFFER_BYTES(SEQ_BYTES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_in      (i_byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_char_out     (o_char_out),
        .o_final_char   (o_final_char),
        .o_first_number (o_first_number),
        .o_second_number(o_second_number),
        .o_last         (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // stimulus and prediction state
    t_stim_row   stim_q[$];
    int unsigned stim_total = 0;
    t_csi_result expected_results[$];
    t_csi_result step_results[$];
    logic [7:0]  held_bytes[SEQ_BYTES];
    int unsigned held_len = 0;

    int unsigned in_cnt = 0;
    int unsigned out_cnt = 0;
    int unsigned cmd_cnt = 0;
    int unsigned errors = 0;
    int unsigned cycle_cnt = 0;

    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    function automatic t_csi_result pass_item(input logic [7:0] b);
        t_csi_result r;
        r = '0;
        r.ch = b;
        return r;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_final(input logic [7:0] c);
        return (c >= CH_UA && c <= CH_UH) || c == CH_UJ || c == CH_UK ||
               c == CH_LH || c == CH_LL || c == CH_LM;
    endfunction

    // decimal accumulate, saturating at the six-digit limit
    function automatic int unsigned add_digit(input int unsigned v, input logic [7:0] c);
        int unsigned r;
        r = v * 10 + int'(c - CH_0);
        return (r > int'(NUM_LIMIT)) ? int'(NUM_LIMIT) : r;
    endfunction

    function automatic void replay_held();
        for (int unsigned k = 0; k < held_len && k < SEQ_BYTES; k++)
            step_results.push_back(pass_item(held_bytes[k]));
    endfunction

    // rescans the held sequence from the start on every byte added to it
    function automatic void parse_console_byte(input logic [7:0] b);
        t_scan_state st;
        int unsigned i;
        int unsigned n1;
        int unsigned n2;
        bit          fail;
        bit          done;
        bit          adv;
        logic [7:0]  c;
        logic [7:0]  fin;
        t_csi_result r;
        step_results.delete();
        st = ST_ESC;
        i = 0;
        n1 = 0;
        n2 = 0;
        fail = 1'b0;
        done = 1'b0;
        fin = 8'h00;
        if (b == CH_ESC) begin
            replay_held();
            held_bytes[0] = CH_ESC;
            held_len = 1;
        end else if (held_len == 0) begin
            step_results.push_back(pass_item(b));
        end else begin
            if (held_len < SEQ_BYTES)
                held_bytes[held_len] = b;
            held_len++;
            if (held_len >= SEQ_BYTES) begin
                held_len = SEQ_BYTES;
                fail = 1'b1;
            end
            while (!fail && i < held_len) begin
                c = held_bytes[i];
                adv = 1'b1;
                case (st)
                    ST_ESC: begin
                        if (c == CH_ESC) st = ST_BRACKET;
                        else fail = 1'b1;
                    end
                    ST_BRACKET: begin
                        if (c == CH_LBRACKET) st = ST_LEAD;
                        else fail = 1'b1;
                    end
                    ST_LEAD: begin
                        if (is_digit(c)) begin
                            n1 = add_digit(0, c);
                            st = ST_NUM1;
                        end else if (c != CH_QMARK) begin
                            n1 = 1;
                            st = ST_SEMI;
                            adv = 1'b0;
                        end
                    end
                    ST_NUM1: begin
                        if (is_digit(c)) begin
                            n1 = add_digit(n1, c);
                        end else begin
                            st = ST_SEMI;
                            adv = 1'b0;
                        end
                    end
                    ST_SEMI: begin
                        if (c == CH_SEMI) begin
                            st = ST_NUM2F;
                        end else begin
                            st = ST_FINAL;
                            adv = 1'b0;
                        end
                    end
                    ST_NUM2F: begin
                        if (is_digit(c)) begin
                            n2 = add_digit(0, c);
                            st = ST_NUM2;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    ST_NUM2: begin
                        if (is_digit(c)) begin
                            n2 = add_digit(n2, c);
                        end else begin
                            st = ST_FINAL;
                            adv = 1'b0;
                        end
                    end
                    default: begin
                        if (is_final(c)) begin
                            fin = c;
                            done = 1'b1;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                endcase
                if (adv)
                    i++;
            end
            if (fail) begin
                replay_held();
                held_len = 0;
            end else if (done) begin
                r = '0;
                r.kind = 1'b1;
                r.fin = fin;
                r.n1 = n1[NUM_W-1:0];
                r.n2 = n2[NUM_W-1:0];
                step_results.push_back(r);
                held_len = 0;
            end
        end
        if (step_results.size() > 0) begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
        end
    endfunction

    function automatic t_stim_row plain_row(input logic [7:0] b);
        t_stim_row r;
        r = '0;
        r.data = b;
        return r;
    endfunction

    function automatic t_stim_row typed_pass_row(input logic [7:0] b);
        t_stim_row r;
        r = plain_row(b);
        r.typed = 1'b1;
        r.want = pass_item(b);
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic t_stim_row typed_cmd_row(input logic [7:0] fin,
                                                input logic [NUM_W-1:0] n1,
                                                input logic [NUM_W-1:0] n2);
        t_stim_row r;
        r = plain_row(fin);
        r.typed = 1'b1;
        r.want.kind = 1'b1;
        r.want.fin = fin;
        r.want.n1 = n1;
        r.want.n2 = n2;
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic t_stim_row directed_row(input int unsigned k);
        case (k)
            0:  return typed_pass_row(8'h00);
            1:  return typed_pass_row(8'hFF);
            2:  return plain_row(CH_ESC);      // nothing held: no transfer
            3:  return plain_row(CH_LBRACKET);
            4:  return plain_row(CH_QMARK);    // repeated '?' skipped
            5:  return plain_row(CH_QMARK);
            6:  return plain_row(8'h37);
            7:  return plain_row(CH_SEMI);
            8:  return plain_row(8'h35);
            9:  return plain_row(CH_LH);
            10: return plain_row(CH_ESC);
            11: return plain_row(CH_LBRACKET);
            12: return typed_cmd_row(CH_UA, 20'd1, 20'd0);
            13: return plain_row(CH_ESC);
            14: return plain_row(8'h33);       // illegal after ESC
            15: return plain_row(CH_ESC);
            16: return plain_row(CH_LBRACKET);
            17: return plain_row(CH_SEMI);
            18: return plain_row(CH_LM);       // no digit after ';'
            19: return plain_row(CH_ESC);
            20: return plain_row(CH_LBRACKET);
            21: return plain_row(8'h34);
            22: return plain_row(CH_ESC);      // ESC mid-sequence, replay and keep
            23: return plain_row(CH_LBRACKET);
            default: return plain_row(CH_9);   // nines until the buffer fills
        endcase
    endfunction

    function automatic logic [7:0] pick_final();
        int unsigned k;
        k = $urandom_range(0, 12);
        case (k)
            8:  return CH_UJ;
            9:  return CH_UK;
            10: return CH_LH;
            11: return CH_LL;
            12: return CH_LM;
            default: return CH_UA + k[7:0];
        endcase
    endfunction

    function automatic logic [7:0] pick_digit(input bit nines);
        return nines ? CH_9 : CH_0 + 8'($urandom_range(0, 9));
    endfunction

    // well-formed sequence with random content, optionally with one byte spoilt
    function automatic int unsigned push_random_sequence(input bit broken);
        logic [7:0]  seq[$];
        int unsigned len1;
        int unsigned len2;
        int unsigned pos;
        bit          nines;
        seq.push_back(CH_ESC);
        seq.push_back(CH_LBRACKET);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) seq.push_back(CH_QMARK);
        end
        nines = ($urandom_range(0, 1) == 1);
        if ($urandom_range(0, 7) == 0) begin
            repeat (6) seq.push_back(pick_digit(nines));
        end else begin
            len1 = $urandom_range(0, 3);
            repeat (len1) seq.push_back(pick_digit(1'b0));
            if ($urandom_range(0, 1) == 1) begin
                seq.push_back(CH_SEMI);
                len2 = $urandom_range(1, 3);
                repeat (len2) seq.push_back(pick_digit(nines && len2 == 3));
            end
        end
        seq.push_back(pick_final());
        if (broken) begin
            pos = $urandom_range(1, seq.size() - 1);
            seq[pos] = 8'($urandom_range(0, 255));
        end
        foreach (seq[k])
            stim_q.push_back(plain_row(seq[k]));
        return seq.size();
    endfunction

    function automatic int unsigned idle_pct(input int unsigned n, input bit receiver);
        int unsigned phase;
        phase = (stim_total == 0) ? 0 : (n * 3) / stim_total;
        case (phase)
            0:       return receiver ? 49 : 34;
            1:       return receiver ? 34 : 49;
            default: return 0;
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [NUM_W-1:0] want,
                                 input logic [NUM_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        t_csi_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual kind %0d char %0d fin %0d",
                     $time, o_kind, o_char_out, o_final_char);
            errors++;
        end else begin
            want = expected_results.pop_front();
            compare_field("kind", NUM_W'(want.kind), NUM_W'(o_kind));
            compare_field("char_out", NUM_W'(want.ch), NUM_W'(o_char_out));
            compare_field("final_char", NUM_W'(want.fin), NUM_W'(o_final_char));
            compare_field("first_number", want.n1, o_first_number);
            compare_field("second_number", want.n2, o_second_number);
            compare_field("last", NUM_W'(want.last), NUM_W'(o_last));
            if (want.kind)
                cmd_cnt++;
        end
        out_cnt++;
    endtask

    task automatic accept_byte(input t_stim_row row);
        parse_console_byte(row.data);
        if (row.typed)
            expected_results.push_back(row.want);
        else
            foreach (step_results[k])
                expected_results.push_back(step_results[k]);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                accept_byte(stim_q[in_cnt]);
                in_cnt++;
            end
            if (o_out_valid && !i_out_stall)
                check_result();
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("ansi_csi_sequence_parser_core test failed");
            $finish;
        end
    end

    // receiver: random stall, plus one long hold-off late in the run
    always @(negedge i_clk) begin
        if (!hold_done && stim_total != 0 && in_cnt >= (stim_total * 3) / 4) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < idle_pct(in_cnt, 1'b1));
        end
    end

    initial begin
        int unsigned random_bytes;
        int unsigned mode;
        int unsigned pause_at;

        for (int unsigned k = 0; k < DIRECTED_ROWS; k++)
            stim_q.push_back(directed_row(k));
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            mode = $urandom_range(0, 99);
            if (mode < 25) begin
                stim_q.push_back(plain_row(8'($urandom_range(0, 255))));
                random_bytes++;
            end else begin
                random_bytes += push_random_sequence(mode >= 80);
            end
        end
        stim_total = stim_q.size();
        pause_at = (stim_total * 9) / 10;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int unsigned idx = 0; idx < stim_total; idx++) begin
            @(negedge i_clk);
            if (idx == pause_at) begin
                // let the output side drain completely before going on
                i_in_valid <= 1'b0;
                while (expected_results.size() != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            while ($urandom_range(0, 99) < idle_pct(idx, 1'b0)) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_byte_in <= stim_q[idx].data;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d input transfers (%0d from the table), %0d results, %0d commands",
                 in_cnt, DIRECTED_ROWS, out_cnt, cmd_cnt);
        $display("three idle mixes, one long output hold-off and one drain pause");
        if (errors == 0) begin
            $display("ansi_csi_sequence_parser_core test passed");
        end else begin
            $display("ansi_csi_sequence_parser_core test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/acsp_pkg.sv
sv/acsp_parse.sv
sv/ansi_csi_sequence_parser_core.sv
tb/sv/ansi_csi_sequence_parser_core_test.sv
